[hdl/sard_pkg.sv]
// shared types, constants and codes for the sensor advert record decoder
package sard_pkg;

    localparam int MAX_RECORD_BYTES_DEF = 24;
    localparam int DECODE_BYTES         = 24;
    localparam int LEN_W                = 6;

    localparam logic [15:0]      COMPANY_CODE = 16'h0702;
    localparam logic [LEN_W-1:0] SHORT_LEN    = LEN_W'(22);
    localparam logic [LEN_W-1:0] LONG_LEN     = LEN_W'(24);
    localparam int               INTEG_BIT    = 5;

    typedef enum logic [2:0] {
        ST_NOT_OURS = 3'd0,
        ST_BAD_LEN  = 3'd1,
        ST_NO_INTEG = 3'd2,
        ST_BAD_TYPE = 3'd3,
        ST_REPEAT   = 3'd4,
        ST_NEW      = 3'd5
    } status_t;

    localparam logic [1:0] KIND_GAS       = 2'd0;
    localparam logic [1:0] KIND_CLIMATE   = 2'd1;
    localparam logic [1:0] KIND_RADIATION = 2'd2;
    localparam logic [1:0] KIND_RADON     = 2'd3;

    typedef logic [DECODE_BYTES-1:0][7:0] rec_t;

    // completed record waiting for decode
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [15:0]       company_id;
        logic [47:0]       sender_address;
        logic signed [7:0] rssi;
    } pend_t;

    typedef struct packed {
        status_t           status;
        logic [1:0]        device_kind;
        logic signed [7:0] rssi_out;
        logic [15:0]       sample_age;
        logic [15:0]       sample_interval;
        logic [7:0]        battery_level;
        logic [31:0]       primary_reading;
        logic [31:0]       secondary_reading;
        logic [15:0]       pressure_raw;
        logic [15:0]       humidity_or_rate;
        logic [1:0]        readings_valid;
    } res_t;

endpackage

[hdl/sard_capture.sv]
// record byte buffer, byte counter and pending-decode register
module sard_capture #(
    parameter int MAX_RECORD_BYTES = sard_pkg::MAX_RECORD_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              advance,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [15:0]       company_id,
    input  logic [47:0]       sender_address,
    input  logic signed [7:0] signal_strength,
    output logic              pend_vld,
    output sard_pkg::pend_t   pend,
    output sard_pkg::rec_t    rec
);
    import sard_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 2);
    localparam int IDX_W = $clog2(MAX_RECORD_BYTES);
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_RECORD_BYTES);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_RECORD_BYTES + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_inc;
    logic [7:0]       buf_reg [MAX_RECORD_BYTES];
    logic             pend_vld_reg, pend_vld_next;
    pend_t            pend_reg;

    // saturating count including the byte being taken
    assign count_inc = (count_reg < CNT_SAT) ? count_reg + CNT_W'(1) : count_reg;

    always_comb begin
        count_next    = count_reg;
        pend_vld_next = pend_vld_reg;
        if (advance) begin
            pend_vld_next = 1'b0;
        end
        if (accept) begin
            count_next = last_byte ? '0 : count_inc;
            if (last_byte) begin
                pend_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && count_reg < CNT_LIM) begin
            buf_reg[count_reg[IDX_W-1:0]] <= data_byte;
        end
        if (accept && last_byte) begin
            pend_reg.len            <= LEN_W'(count_inc);
            pend_reg.company_id     <= company_id;
            pend_reg.sender_address <= sender_address;
            pend_reg.rssi           <= signal_strength;
        end
    end

    always_comb begin
        for (int i = 0; i < DECODE_BYTES; i++) begin
            rec[i] = buf_reg[i];
        end
    end

    assign pend_vld = pend_vld_reg;
    assign pend     = pend_reg;

endmodule

[hdl/sard_decode.sv]
// record checks and field extraction, purely combinational
module sard_decode (
    input  sard_pkg::pend_t pend,
    input  sard_pkg::rec_t  rec,
    input  logic [47:0]     expected_address,
    input  logic [7:0]      last_counter,
    input  logic            counter_seen,
    output sard_pkg::res_t  res,
    output logic [7:0]      counter
);
    import sard_pkg::*;

    logic       long_rec;
    logic [7:0] hdr;
    logic [7:0] kind_byte;

    assign long_rec  = (pend.len == LONG_LEN);
    assign kind_byte = long_rec ? rec[0] : 8'd0;
    assign hdr       = long_rec ? rec[1] : rec[0];
    assign counter   = long_rec ? rec[23] : rec[21];

    always_comb begin
        res = '0;
        if (pend.sender_address != expected_address
                || pend.company_id != COMPANY_CODE) begin
            res.status = ST_NOT_OURS;
        end else if (pend.len != SHORT_LEN && !long_rec) begin
            res.status = ST_BAD_LEN;
        end else if (!hdr[INTEG_BIT]) begin
            res.status = ST_NO_INTEG;
        end else if (long_rec && (kind_byte == 8'd0 || kind_byte > 8'd3)) begin
            res.status = ST_BAD_TYPE;
        end else begin
            res.device_kind = kind_byte[1:0];
            res.rssi_out    = pend.rssi;
            res.sample_age  = long_rec ? {rec[22], rec[21]} : {rec[20], rec[19]};
            if (counter_seen && counter == last_counter) begin
                res.status = ST_REPEAT;
            end else begin
                res.status = ST_NEW;
                res.sample_interval = long_rec ? {rec[20], rec[19]}
                                               : {rec[18], rec[17]};
                res.battery_level = long_rec ? rec[17] : rec[15];
                case (kind_byte[1:0])
                    KIND_GAS: begin
                        res.primary_reading   = {16'd0, rec[9], rec[8]};
                        res.secondary_reading = {16'd0, rec[11], rec[10]};
                        res.pressure_raw      = {rec[13], rec[12]};
                        res.humidity_or_rate  = {8'd0, rec[14]};
                        res.readings_valid    = 2'b11;
                    end
                    KIND_CLIMATE: begin
                        res.secondary_reading = {16'd0, rec[11], rec[10]};
                        res.humidity_or_rate  = {rec[15], rec[14]};
                        res.readings_valid    = 2'b11;
                    end
                    KIND_RADON: begin
                        res.primary_reading   = {16'd0, rec[9], rec[8]};
                        res.secondary_reading = {16'd0, rec[11], rec[10]};
                        res.pressure_raw      = {rec[13], rec[12]};
                        res.humidity_or_rate  = {rec[15], rec[14]};
                        // zero raw value means the sensor has no reading
                        res.readings_valid    = {({rec[15], rec[14]} != 16'd0),
                                                 ({rec[11], rec[10]} != 16'd0)};
                    end
                    default: begin
                        res.primary_reading   = {rec[9], rec[8], rec[7], rec[6]};
                        res.secondary_reading = {rec[13], rec[12], rec[11], rec[10]};
                        res.humidity_or_rate  = {rec[15], rec[14]};
                        res.readings_valid    = 2'b00;
                    end
                endcase
            end
        end
    end

endmodule

[hdl/sensor_advert_record_decoder.sv]
// top level: sensor advert record decoder with output register and counter state
//
// Takes a manufacturer-data record one byte per transaction on the s_ channel
// and, for every byte flagged s_last_byte, delivers exactly one decoded
// transaction on the m_ channel. Bytes are written into a small register
// buffer as they arrive; the last byte also captures company id, sender
// address and signal strength into a pending register. Once the record is
// pending and the output register is free, one pass of combinational checks
// and field extraction fills the output register, so a result is presented
// on m_ after the pending and output registers. Throughput is one byte per
// cycle while s_ready is high. While a decoded result is held in the output
// register and another completed record is waiting behind it, s_ready drops,
// because the next byte would overwrite the buffer the waiting record still
// needs. The measurement counter of the last new result is kept so a
// repeated broadcast is reported as a repeat with only device kind, age and
// signal strength. Records longer than MAX_RECORD_BYTES are not stored past
// that point and fail the length check. cfg_wr_data is the accepted sender
// address; write it only while the block is idle.
module sensor_advert_record_decoder #(
    parameter int MAX_RECORD_BYTES = sard_pkg::MAX_RECORD_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [47:0]       cfg_wr_data,
    // record byte stream
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_last_byte,
    input  logic [15:0]       s_company_id,
    input  logic [47:0]       s_sender_address,
    input  logic signed [7:0] s_signal_strength,
    // decoded results
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [1:0]        m_device_kind,
    output logic signed [7:0] m_rssi_out,
    output logic [15:0]       m_sample_age,
    output logic [15:0]       m_sample_interval,
    output logic [7:0]        m_battery_level,
    output logic [31:0]       m_primary_reading,
    output logic [31:0]       m_secondary_reading,
    output logic [15:0]       m_pressure_raw,
    output logic [15:0]       m_humidity_or_rate,
    output logic [1:0]        m_readings_valid
);
    import sard_pkg::*;

    logic [47:0] exp_addr_reg;
    logic [7:0]  last_counter_reg, last_counter_next;
    logic        counter_seen_reg, counter_seen_next;
    logic        m_valid_reg, m_valid_next;
    res_t        res_reg;

    logic  s_accept;
    logic  out_free;
    logic  fire;
    logic  pend_vld;
    pend_t pend;
    rec_t  rec;
    res_t  dec_res;
    logic [7:0] dec_counter;

    // output register can take a new result this cycle
    assign out_free = !m_valid_reg || m_ready;
    // pending record moves into the output register
    assign fire     = pend_vld && out_free;
    // hold off bytes only when a finished record is stuck behind a full output
    assign s_ready  = !pend_vld || out_free;
    assign s_accept = s_valid && s_ready;

    sard_capture #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_capture (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (s_accept),
        .advance         (fire),
        .data_byte       (s_data_byte),
        .last_byte       (s_last_byte),
        .company_id      (s_company_id),
        .sender_address  (s_sender_address),
        .signal_strength (s_signal_strength),
        .pend_vld        (pend_vld),
        .pend            (pend),
        .rec             (rec)
    );

    sard_decode u_decode (
        .pend             (pend),
        .rec              (rec),
        .expected_address (exp_addr_reg),
        .last_counter     (last_counter_reg),
        .counter_seen     (counter_seen_reg),
        .res              (dec_res),
        .counter          (dec_counter)
    );

    // counter state follows new measurements only
    always_comb begin
        last_counter_next = last_counter_reg;
        counter_seen_next = counter_seen_reg;
        m_valid_next      = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (fire) begin
            m_valid_next = 1'b1;
            if (dec_res.status == ST_NEW) begin
                last_counter_next = dec_counter;
                counter_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_addr_reg     <= '0;
            last_counter_reg <= '0;
            counter_seen_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                exp_addr_reg <= cfg_wr_data;
            end
            last_counter_reg <= last_counter_next;
            counter_seen_reg <= counter_seen_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // result payload, loaded on each decode
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= dec_res;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = res_reg.status;
    assign m_device_kind       = res_reg.device_kind;
    assign m_rssi_out          = res_reg.rssi_out;
    assign m_sample_age        = res_reg.sample_age;
    assign m_sample_interval   = res_reg.sample_interval;
    assign m_battery_level     = res_reg.battery_level;
    assign m_primary_reading   = res_reg.primary_reading;
    assign m_secondary_reading = res_reg.secondary_reading;
    assign m_pressure_raw      = res_reg.pressure_raw;
    assign m_humidity_or_rate  = res_reg.humidity_or_rate;
    assign m_readings_valid    = res_reg.readings_valid;

    // input stalls only behind a blocked output register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (pend_vld && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // interval and battery are only reported on a new measurement
    a_new_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_NEW) |->
            (m_sample_interval == 16'd0 && m_battery_level == 8'd0))
        else $error("interval or battery set on a non-new result");

    // counter state is armed only by a new measurement leaving decode
    a_seen_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(counter_seen_reg) |-> $past(fire && dec_res.status == ST_NEW))
        else $error("counter seen set without a new result");

    // a decode always produces a result in the next cycle
    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("decoded record lost");

endmodule
